### hdl/nnds_pkg.sv
// Shared types, constants and channel expansion tables for the
// nearest-neighbor RGB565 downscaler. No dependencies.
package nnds_pkg;

  localparam int SIDE_W     = 11;
  localparam int PROD_W     = 2 * SIDE_W;
  localparam int PIX_W      = 16;
  localparam int CH_W       = 8;
  localparam int MAX_SIDE   = 1024;
  localparam int FIFO_DEPTH = 4;
  localparam int CFG_ADDR_W = 2;

  localparam logic [SIDE_W-1:0] MAX_SIDE_V = SIDE_W'(MAX_SIDE);

  localparam logic [SIDE_W-1:0] RST_SRC_WIDTH  = SIDE_W'(240);
  localparam logic [SIDE_W-1:0] RST_SRC_HEIGHT = SIDE_W'(240);
  localparam logic [SIDE_W-1:0] RST_OUT_COLS   = SIDE_W'(224);
  localparam logic [SIDE_W-1:0] RST_OUT_ROWS   = SIDE_W'(224);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_OUT_COLS   = 2'd2,
    CFG_OUT_ROWS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } kept_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [SIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SIDE_W-1:0] quotient;
    logic [SIDE_W-1:0] remainder;
  } div_rsp_t;

  typedef logic [CH_W-1:0] lut5_t [32];
  typedef logic [CH_W-1:0] lut6_t [64];

  // floor(c*255/max) - 128, as two's complement bytes
  function automatic lut5_t build_lut5();
    lut5_t lut;
    for (int i = 0; i < 32; i++) begin
      lut[i] = CH_W'((i * 255) / 31 - 128);
    end
    return lut;
  endfunction

  function automatic lut6_t build_lut6();
    lut6_t lut;
    for (int i = 0; i < 64; i++) begin
      lut[i] = CH_W'((i * 255) / 63 - 128);
    end
    return lut;
  endfunction

  localparam lut5_t EXP5_LUT = build_lut5();
  localparam lut6_t EXP6_LUT = build_lut6();

endpackage

### hdl/nnds_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nnds_pkg.
module nnds_div (
  input  logic               clk,
  input  logic               rst_n,
  input  nnds_pkg::div_req_t req,
  output nnds_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(nnds_pkg::PROD_W + 1);

  logic [nnds_pkg::SIDE_W-1:0] rem_r;
  logic [nnds_pkg::SIDE_W-1:0] dvs_r;
  logic [nnds_pkg::PROD_W-1:0] quo_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [nnds_pkg::SIDE_W:0] trial;
  logic [nnds_pkg::SIDE_W:0] diff;
  logic                      ge;

  assign trial = {rem_r, quo_r[nnds_pkg::PROD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(nnds_pkg::PROD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[nnds_pkg::SIDE_W-1:0] : trial[nnds_pkg::SIDE_W-1:0];
      quo_r <= {quo_r[nnds_pkg::PROD_W-2:0], ge};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r[nnds_pkg::SIDE_W-1:0];
  assign rsp.remainder = rem_r;

endmodule

### hdl/nnds_front.sv
// Front end: size registers, source/destination counters, sample point
// tracking and keep decision. Depends on nnds_pkg and nnds_div.
module nnds_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nnds_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [nnds_pkg::SIDE_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nnds_pkg::PIX_W-1:0]        in_pixel,
  input  logic                              in_frame_start,
  input  logic                              fifo_full,
  output logic                              push,
  output nnds_pkg::kept_t                   push_data
);

  localparam int W = nnds_pkg::SIDE_W;

  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_START = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    OP_COL_STEP = 2'd0,
    OP_ROW_STEP = 2'd1,
    OP_COL_POS  = 2'd2,
    OP_ROW_POS  = 2'd3
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [W-1:0] src_width_r, src_height_r, out_cols_r, out_rows_r;

  logic [W-1:0] sc_r, sr_r, dc_r, dr_r, smc_r, smr_r, rc_r, rr_r;
  logic [W-1:0] sc_nxt, sr_nxt, dc_nxt, dr_nxt, smc_nxt, smr_nxt, rc_nxt, rr_nxt;
  logic [W-1:0] qc_r, rcs_r, qr_r, rrs_r;

  logic [nnds_pkg::PROD_W-1:0] prod_r;

  nnds_pkg::div_req_t div_req;
  nnds_pkg::div_rsp_t div_rsp;

  logic [W-1:0] w, h, oc_c, orr_c, oc, orr;
  logic [W-1:0] mul_a, mul_b;
  logic         col_op;

  logic [W-1:0] c_sc, c_sr, c_dc, c_dr, c_smc, c_smr, c_rc, c_rr;
  logic         in_fire, active, hit, eol, last_px;
  logic [W:0]   col_sum, row_sum;
  logic         col_wrap, row_wrap;
  logic [W-1:0] col_rem_inc, col_smp_inc, row_rem_inc, row_smp_inc;

  function automatic logic [W-1:0] clamp_side(logic [W-1:0] v);
    if (v == '0) return W'(1);
    if (v > nnds_pkg::MAX_SIDE_V) return nnds_pkg::MAX_SIDE_V;
    return v;
  endfunction

  assign w     = clamp_side(src_width_r);
  assign h     = clamp_side(src_height_r);
  assign oc_c  = clamp_side(out_cols_r);
  assign orr_c = clamp_side(out_rows_r);
  assign oc    = (oc_c > w) ? w : oc_c;
  assign orr   = (orr_c > h) ? h : orr_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= nnds_pkg::RST_SRC_WIDTH;
      src_height_r <= nnds_pkg::RST_SRC_HEIGHT;
      out_cols_r   <= nnds_pkg::RST_OUT_COLS;
      out_rows_r   <= nnds_pkg::RST_OUT_ROWS;
    end else if (cfg_we) begin
      unique case (nnds_pkg::cfg_idx_t'(cfg_addr))
        nnds_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        nnds_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        nnds_pkg::CFG_OUT_COLS:   out_cols_r   <= cfg_wdata;
        nnds_pkg::CFG_OUT_ROWS:   out_rows_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Recompute of step sizes and sample points after reset or a size write
  assign col_op = (op_r == OP_COL_STEP) || (op_r == OP_COL_POS);

  always_comb begin
    case (op_r)
      OP_COL_POS: mul_a = dc_r;
      OP_ROW_POS: mul_a = dr_r;
      default:    mul_a = W'(1);
    endcase
    mul_b = col_op ? w : h;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_r <= (nnds_pkg::PROD_W)'(mul_a) * (nnds_pkg::PROD_W)'(mul_b);
    end
  end

  assign div_req.start    = (state_r == ST_START);
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = col_op ? oc : orr;

  nnds_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_RUN:   ;
      ST_MUL:   state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) begin
          if (op_r == OP_ROW_POS) begin
            state_nxt = ST_RUN;
          end else begin
            op_nxt    = op_t'(op_r + 2'd1);
            state_nxt = ST_MUL;
          end
        end
      end
      default: state_nxt = ST_MUL;
    endcase
    if (cfg_we) begin
      state_nxt = ST_MUL;
      op_nxt    = OP_COL_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_MUL;
      op_r    <= OP_COL_STEP;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WAIT && div_rsp.done) begin
      case (op_r)
        OP_COL_STEP: begin
          qc_r  <= div_rsp.quotient;
          rcs_r <= div_rsp.remainder;
        end
        OP_ROW_STEP: begin
          qr_r  <= div_rsp.quotient;
          rrs_r <= div_rsp.remainder;
        end
        default: ;
      endcase
    end
  end

  // Per-item counting
  assign in_ready = (state_r == ST_RUN) && !fifo_full;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (in_frame_start) begin
      c_sc  = '0; c_sr  = '0; c_dc = '0; c_dr = '0;
      c_smc = '0; c_smr = '0; c_rc = '0; c_rr = '0;
    end else begin
      c_sc  = sc_r;  c_sr  = sr_r;  c_dc = dc_r; c_dr = dr_r;
      c_smc = smc_r; c_smr = smr_r; c_rc = rc_r; c_rr = rr_r;
    end
  end

  assign active  = (c_sr < h) && (c_dr < orr);
  assign hit     = active && (c_sr == c_smr) && (c_sc == c_smc) && (c_dc < oc);
  assign last_px = (c_dr == orr - W'(1)) && (c_dc == oc - W'(1));
  assign eol     = ({1'b0, c_sc} + (W+1)'(1)) >= {1'b0, w};

  assign col_sum     = {1'b0, c_rc} + {1'b0, rcs_r};
  assign col_wrap    = col_sum >= {1'b0, oc};
  assign col_rem_inc = col_wrap ? W'(col_sum - {1'b0, oc}) : col_sum[W-1:0];
  assign col_smp_inc = c_smc + qc_r + W'(col_wrap);

  assign row_sum     = {1'b0, c_rr} + {1'b0, rrs_r};
  assign row_wrap    = row_sum >= {1'b0, orr};
  assign row_rem_inc = row_wrap ? W'(row_sum - {1'b0, orr}) : row_sum[W-1:0];
  assign row_smp_inc = c_smr + qr_r + W'(row_wrap);

  always_comb begin
    sc_nxt  = sc_r;  sr_nxt  = sr_r;  dc_nxt = dc_r; dr_nxt = dr_r;
    smc_nxt = smc_r; smr_nxt = smr_r; rc_nxt = rc_r; rr_nxt = rr_r;
    if (state_r == ST_WAIT && div_rsp.done) begin
      case (op_r)
        OP_COL_POS: begin
          smc_nxt = div_rsp.quotient;
          rc_nxt  = div_rsp.remainder;
        end
        OP_ROW_POS: begin
          smr_nxt = div_rsp.quotient;
          rr_nxt  = div_rsp.remainder;
        end
        default: ;
      endcase
    end
    if (in_fire) begin
      sc_nxt  = c_sc;  sr_nxt  = c_sr;  dc_nxt = c_dc; dr_nxt = c_dr;
      smc_nxt = c_smc; smr_nxt = c_smr; rc_nxt = c_rc; rr_nxt = c_rr;
      if (active) begin
        if (hit) begin
          dc_nxt  = c_dc + W'(1);
          smc_nxt = col_smp_inc;
          rc_nxt  = col_rem_inc;
        end
        if (eol) begin
          if (c_sr == c_smr) begin
            dr_nxt  = c_dr + W'(1);
            smr_nxt = row_smp_inc;
            rr_nxt  = row_rem_inc;
          end
          dc_nxt  = '0;
          smc_nxt = '0;
          rc_nxt  = '0;
          sc_nxt  = '0;
          sr_nxt  = c_sr + W'(1);
        end else begin
          sc_nxt = c_sc + W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r  <= '0; sr_r  <= '0; dc_r <= '0; dr_r <= '0;
      smc_r <= '0; smr_r <= '0; rc_r <= '0; rr_r <= '0;
    end else begin
      sc_r  <= sc_nxt;  sr_r  <= sr_nxt;  dc_r <= dc_nxt; dr_r <= dr_nxt;
      smc_r <= smc_nxt; smr_r <= smr_nxt; rc_r <= rc_nxt; rr_r <= rr_nxt;
    end
  end

  assign push                = in_fire && hit;
  assign push_data.pixel     = in_pixel;
  assign push_data.frame_end = last_px;

endmodule

### hdl/nnds_fifo.sv
// Short queue of kept pixels between front and back end.
// Depends on nnds_pkg.
module nnds_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  nnds_pkg::kept_t push_data,
  output logic            full,
  input  logic            pop,
  output nnds_pkg::kept_t pop_data,
  output logic            empty
);

  localparam int DEPTH = nnds_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  nnds_pkg::kept_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

### hdl/nnds_back.sv
// Back end: widens RGB565 channels to offset int8 and holds the result
// register. Depends on nnds_pkg.
module nnds_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        empty,
  input  nnds_pkg::kept_t             pop_data,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nnds_pkg::CH_W-1:0]   out_red,
  output logic [nnds_pkg::CH_W-1:0]   out_green,
  output logic [nnds_pkg::CH_W-1:0]   out_blue,
  output logic                        out_frame_end
);

  logic                      valid_r;
  logic [nnds_pkg::CH_W-1:0] red_r, green_r, blue_r;
  logic                      fe_r;

  assign pop = !empty && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      red_r   <= nnds_pkg::EXP5_LUT[pop_data.pixel[15:11]];
      green_r <= nnds_pkg::EXP6_LUT[pop_data.pixel[10:5]];
      blue_r  <= nnds_pkg::EXP5_LUT[pop_data.pixel[4:0]];
      fe_r    <= pop_data.frame_end;
    end
  end

  assign out_valid     = valid_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_frame_end = fe_r;

endmodule

### hdl/nn_downscale_rgb565_to_int8_unit.sv
// Nearest-neighbor RGB565 downscaler, top level; uses nnds_pkg, nnds_front,
// nnds_fifo and nnds_back.
// Throughput: one source pixel per cycle while the FIFO is not full and no recompute
// runs; a kept pixel passes through the FIFO and the output register to the output.
// Synchronous reset (rst_n low) and every size write start a recompute of step
// sizes and sample points, during which in_tready is low.
module nn_downscale_rgb565_to_int8_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nnds_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [nnds_pkg::SIDE_W-1:0]     cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] pixel
  input  logic                            in_tuser,   // [0] frame_start
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic                            out_tlast
);

  logic            push, full, pop, empty;
  nnds_pkg::kept_t push_data, pop_data;

  nnds_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_pixel       (in_tdata),
    .in_frame_start (in_tuser),
    .fifo_full      (full),
    .push           (push),
    .push_data      (push_data)
  );

  nnds_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  nnds_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_red       (out_tdata[7:0]),
    .out_green     (out_tdata[15:8]),
    .out_blue      (out_tdata[23:16]),
    .out_frame_end (out_tlast)
  );

endmodule

### hdl/nnds_checker.sv
// Port-level checks for the downscaler top level, bound to it below.
// Uses no package.
module nnds_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output item changed");

  a_rst_out_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_rst_recalc: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during post-reset recompute");

  a_cfg_recalc: assert property (@(posedge clk)
    cfg_we |=> !in_tready)
    else $error("input ready right after size write");

endmodule

bind nn_downscale_rgb565_to_int8_unit nnds_port_props u_nnds_port_props (.*);

### bench/nnds_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the RGB565 nearest-neighbor downscaler: tracks size register writes,
// predicts each kept pixel from accepted input items and checks the result channel.
// Depends on nnds_pkg.
module nnds_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nnds_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [nnds_pkg::SIDE_W-1:0]     cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [15:0]                     in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [23:0]                     out_tdata,
  input  logic                            out_tlast,
  output int unsigned                     fail_count,
  output int unsigned                     pending_count
);

  localparam int CH_W   = nnds_pkg::CH_W;
  localparam int SIDE_W = nnds_pkg::SIDE_W;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } int8_pixel_t;

  int8_pixel_t kept_q[$];

  logic [SIDE_W-1:0] src_width_r, src_height_r, out_cols_r, out_rows_r;
  int unsigned src_col, src_row, dst_col, dst_row;
  int unsigned fails;

  initial fail_count = 0;
  initial pending_count = 0;

  function automatic int unsigned side_of(input logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (v > nnds_pkg::MAX_SIDE_V) return nnds_pkg::MAX_SIDE;
    return 32'(v);
  endfunction

  function automatic logic [CH_W-1:0] widen(input int c, input int top);
    return CH_W'(c * 255 / top - 128);
  endfunction

  task automatic take_source_pixel(input logic [15:0] px, input logic start);
    int unsigned w, h, oc, orr, samp_c, samp_r;
    int8_pixel_t res;
    w   = side_of(src_width_r);
    h   = side_of(src_height_r);
    oc  = side_of(out_cols_r);
    orr = side_of(out_rows_r);
    if (oc > w) oc = w;
    if (orr > h) orr = h;
    if (start) begin
      src_col = 0;
      src_row = 0;
      dst_col = 0;
      dst_row = 0;
    end
    if (src_row >= h || dst_row >= orr) return;
    samp_c = (dst_col * w / oc) & 32'h7FF;
    samp_r = (dst_row * h / orr) & 32'h7FF;
    if (src_row == samp_r && src_col == samp_c && dst_col < oc) begin
      res.red       = widen(32'(px[15:11]), 31);
      res.green     = widen(32'(px[10:5]), 63);
      res.blue      = widen(32'(px[4:0]), 31);
      res.frame_end = (dst_row == orr - 1 && dst_col == oc - 1);
      kept_q.push_back(res);
      dst_col++;
    end
    if (src_col + 1 >= w) begin
      if (src_row == samp_r) dst_row++;
      dst_col = 0;
      src_col = 0;
      src_row++;
    end else begin
      src_col++;
    end
  endtask

  always @(posedge clk) begin : watch
    int8_pixel_t want, got;
    if (!rst_n) begin
      src_width_r  = nnds_pkg::RST_SRC_WIDTH;
      src_height_r = nnds_pkg::RST_SRC_HEIGHT;
      out_cols_r   = nnds_pkg::RST_OUT_COLS;
      out_rows_r   = nnds_pkg::RST_OUT_ROWS;
      src_col = 0;
      src_row = 0;
      dst_col = 0;
      dst_row = 0;
      kept_q.delete();
    end else begin
      if (cfg_we) begin
        case (nnds_pkg::cfg_idx_t'(cfg_addr))
          nnds_pkg::CFG_SRC_WIDTH:  src_width_r  = cfg_wdata;
          nnds_pkg::CFG_SRC_HEIGHT: src_height_r = cfg_wdata;
          nnds_pkg::CFG_OUT_COLS:   out_cols_r   = cfg_wdata;
          nnds_pkg::CFG_OUT_ROWS:   out_rows_r   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_source_pixel(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tlast};
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected item r=%0d g=%0d b=%0d last=%0b", $time,
                   $signed(got.red), $signed(got.green), $signed(got.blue), got.frame_end);
          fails++;
        end else begin
          want = kept_q.pop_front();
          if (got !== want) begin
            $display({"%0t: mismatch expected r=%0d g=%0d b=%0d last=%0b,",
                      " got r=%0d g=%0d b=%0d last=%0b"},
                     $time, $signed(want.red), $signed(want.green), $signed(want.blue),
                     want.frame_end, $signed(got.red), $signed(got.green),
                     $signed(got.blue), got.frame_end);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    pending_count <= 32'(kept_q.size());
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Stimulus and verdict for nn_downscale_rgb565_to_int8_unit: directed corner frames, then
// random frame sizes and pixels under bursty input and stalling output. Uses nnds_checker.
module testbench;

  localparam int SIDE_W       = nnds_pkg::SIDE_W;
  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 1750;

  typedef enum logic [1:0] {RX_OPEN, RX_THREE_OF_FOUR, RX_HALF, RX_SPARSE} rx_mode_t;

  logic                            clk;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [nnds_pkg::CFG_ADDR_W-1:0] cfg_addr  = nnds_pkg::CFG_SRC_WIDTH;
  logic [SIDE_W-1:0]               cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [15:0]                     in_tdata  = '0;
  logic                            in_tuser  = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [23:0]                     out_tdata;
  logic                            out_tlast;

  int unsigned fail_count, pending_count;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  rx_cycle = '0;
  rx_mode_t    rx_mode = RX_OPEN;

  nn_downscale_rgb565_to_int8_unit DUT (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  nnds_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .fail_count, .pending_count
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (rx_cycle[5:0] == '0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:          out_tready <= 1'b1;
      RX_THREE_OF_FOUR: out_tready <= (rx_cycle[1:0] != 2'd0);
      RX_HALF:          out_tready <= 1'($urandom_range(0, 1));
      default:          out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned side_of(input logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (v > nnds_pkg::MAX_SIDE_V) return nnds_pkg::MAX_SIDE;
    return 32'(v);
  endfunction

  task automatic send_pixel(input logic [15:0] px, input logic start);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  // drop valid and wait until every kept pixel is out and the pipe is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_sizes(input logic [SIDE_W-1:0] w, h, c, r);
    cfg_we    <= 1'b1;
    cfg_addr  <= nnds_pkg::CFG_SRC_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr  <= nnds_pkg::CFG_SRC_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_addr  <= nnds_pkg::CFG_OUT_COLS;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_addr  <= nnds_pkg::CFG_OUT_ROWS;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_frames(input logic [SIDE_W-1:0] w, h, c, r, input int unsigned frames);
    int unsigned total, n, mid;
    int kind;
    total = side_of(w) * side_of(h);
    for (int f = 0; f < frames; f++) begin
      kind = $urandom_range(0, 11);
      n = total;
      mid = n + 1;
      if (kind == 0 && n > 1) n = $urandom_range(1, n - 1);
      else if (kind == 1) n = n + $urandom_range(1, 8);
      else if (kind == 2 && n > 1) mid = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++) begin
        if (i == mid) begin
          settle();
          set_sizes(w, h, SIDE_W'($urandom_range(0, side_of(w) + 1)),
                    SIDE_W'($urandom_range(0, side_of(h) + 1)));
        end
        send_pixel(16'($urandom), i == 0);
      end
      // stray pixels without a frame mark
      if (kind == 3) repeat ($urandom_range(1, 4)) send_pixel(16'($urandom), 1'b0);
    end
  endtask

  initial begin : stimulus
    logic [15:0] corner_px [6];
    logic [SIDE_W-1:0] w, h, c, r;
    int unsigned frames, pick, phase;
    corner_px = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h5555};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // cols above source width, rows zero
    set_sizes(11'd3, 11'd2, 11'd5, 11'd0);
    // first frame after reset carries no mark
    foreach (corner_px[i]) send_pixel(corner_px[i], 1'b0);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'h1234, 1'b0);
    // short frame, then a full one
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h0840, 1'b0);
    foreach (corner_px[i]) send_pixel(~corner_px[i], i == 0);
    // row count raised in the middle of a frame
    for (int i = 0; i < 3; i++) send_pixel(16'($urandom), i == 0);
    settle();
    set_sizes(11'd3, 11'd2, 11'd3, 11'd2);
    for (int i = 0; i < 3; i++) send_pixel(16'($urandom), 1'b0);

    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 15);
      frames = $urandom_range(1, 4);
      if (phase == 0) begin
        w = 11'd2047; h = 11'd1; c = 11'd3; r = 11'd0;
      end else if (phase == 1) begin
        w = 11'd0; h = 11'd1500; c = 11'd1; r = 11'd3;
      end else if (pick == 0) begin
        w = SIDE_W'($urandom_range(17, 64)); h = SIDE_W'($urandom_range(0, 2));
        frames = 1;
      end else if (pick == 1) begin
        w = SIDE_W'($urandom_range(0, 2)); h = SIDE_W'($urandom_range(13, 64));
        frames = 1;
      end else begin
        w = SIDE_W'($urandom_range(0, 16)); h = SIDE_W'($urandom_range(0, 12));
      end
      if (phase > 1) begin
        c = ($urandom_range(0, 5) == 0) ? SIDE_W'($urandom_range(0, 2047))
                                        : SIDE_W'($urandom_range(0, side_of(w) + 2));
        r = ($urandom_range(0, 5) == 0) ? SIDE_W'($urandom_range(0, 2047))
                                        : SIDE_W'($urandom_range(0, side_of(h) + 2));
      end
      settle();
      set_sizes(w, h, c, r);
      if (phase < 2) begin
        // saturated side, cut short just past the last sample point
        for (int i = 0; i < 700; i++) send_pixel(16'($urandom), i == 0);
      end else begin
        run_frames(w, h, c, r, frames);
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
